@@ rtl/core/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers shared by the RTL; empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_SYNC(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_SYNC(label, clk, rst, prop, msg)
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

@@ rtl/core/lts_pkg.sv @@
// ----------------------------------------------------------------------------
// lts_pkg
// Field widths, command, status and register codes of the lottery scheduler.
// ----------------------------------------------------------------------------
package lts_pkg;

  localparam int CMD_W      = 2;
  localparam int BURST_W    = 16;
  localparam int NODE_W     = 4;
  localparam int PID_W      = 22;
  localparam int RAND_W     = 32;
  localparam int STATUS_W   = 2;
  localparam int WIDX_W     = 4;
  localparam int TICKET_W   = 13;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 4;

  localparam logic [CMD_W-1:0] CMD_ADD   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DRAW  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_LOCALITY  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PREF_NODE = 2'd1;

  localparam int BURST_DIV    = 10;
  localparam int BASE_TICKETS = 10;
  localparam int BONUS_TICKETS = 5;
  // largest ticket count of one entry: 65535/10 + 10 + 5
  localparam int TICKET_MAX   = 6568;

  // x/10 for any 16-bit x: (x * 52429) >> 19
  localparam int BURST_PROD_W = 32;
  localparam int BURST_RECIP  = 52429;
  localparam int BURST_SHIFT  = 19;

endpackage

@@ rtl/core/lts_divider.sv @@
// ----------------------------------------------------------------------------
// lts_divider
// Restoring divider giving the remainder, one quotient bit per cycle; done
// pulses when the last quotient bit has been formed.
// ----------------------------------------------------------------------------
module lts_divider #(
  parameter int DIVIDEND_W = 32,
  parameter int DIVISOR_W  = 17
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [DIVISOR_W-1:0]  divisor,
  output logic                  busy,
  output logic                  done,
  output logic [DIVISOR_W-1:0]  remainder
);

  localparam int CNT_W = $clog2(DIVIDEND_W + 1);

  logic [CNT_W-1:0]      cnt;
  logic [DIVIDEND_W-1:0] quotient;
  logic [DIVISOR_W-1:0]  dsr;
  logic [DIVISOR_W:0]    trial;
  logic                  q_bit;
  logic [DIVISOR_W-1:0]  rem_next;

  always_comb begin
    trial    = {remainder, quotient[DIVIDEND_W-1]};
    q_bit    = (trial >= {1'b0, dsr});
    rem_next = q_bit ? DIVISOR_W'(trial - {1'b0, dsr}) : trial[DIVISOR_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy      <= 1'b1;
        cnt       <= CNT_W'(DIVIDEND_W);
        quotient  <= dividend;
        remainder <= '0;
        dsr       <= divisor;
      end else if (busy) begin
        remainder <= rem_next;
        quotient  <= {quotient[DIVIDEND_W-2:0], q_bit};
        cnt       <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

@@ rtl/core/lottery_ticket_scheduler.sv @@
// ----------------------------------------------------------------------------
// lottery_ticket_scheduler
// Lottery scheduling table: add entries, draw a winner, clear.
// ----------------------------------------------------------------------------
// One request is taken at a time; in_stall stays high until its result has
// been loaded into the output register. An add computes burst/10 by
// reciprocal multiply, then does one table write. A draw takes the random
// value modulo the ticket total in the divider (32-step modulo), then scans
// the ticket memory one slot at a time, a read state then an accumulate state.
// Clear, refused requests and command 3 go straight to the result state.
// Configuration writes are always accepted (cfg_ready is tied high).
`include "assert_macros.svh"

module lottery_ticket_scheduler #(
  parameter int MAX_ENTRIES = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [lts_pkg::CMD_W-1:0]        command,
  input  logic [lts_pkg::BURST_W-1:0]      run_length,
  input  logic [lts_pkg::NODE_W-1:0]       home_node,
  input  logic [lts_pkg::PID_W-1:0]        process_id,
  input  logic [lts_pkg::RAND_W-1:0]       random_value,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [lts_pkg::STATUS_W-1:0]     status,
  output logic [lts_pkg::WIDX_W-1:0]       winner_index,
  output logic [lts_pkg::PID_W-1:0]        winner_id,
  output logic [lts_pkg::TICKET_W-1:0]     ticket_value,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [lts_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [lts_pkg::CFG_DATA_W-1:0]   cfg_data
);

  import lts_pkg::*;

  localparam int TOT_W = $clog2(MAX_ENTRIES * TICKET_MAX + 1);
  localparam int IW    = $clog2(MAX_ENTRIES);
  localparam int CW    = $clog2(MAX_ENTRIES + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_ADD_WR,
    S_SCAN_RD,
    S_SCAN_ACC,
    S_DONE
  } state_t;

  state_t state;

  logic              locality_enabled;
  logic [NODE_W-1:0] bonus_node;

  logic [CW-1:0]    entry_count;
  logic [TOT_W-1:0] ticket_total;

  logic               cur_bonus;
  logic [PID_W-1:0]   cur_pid;
  logic [BURST_W-1:0] cur_burst;
  logic [TOT_W-1:0]   win;
  logic [TOT_W-1:0]   scan_sum;
  logic [IW-1:0]      scan_idx;

  logic [STATUS_W-1:0] res_status;
  logic [WIDX_W-1:0]   res_widx;
  logic [PID_W-1:0]    res_wid;
  logic [TICKET_W-1:0] res_tval;

  logic [TICKET_W-1:0] ticket_mem [MAX_ENTRIES];
  logic [PID_W-1:0]    id_mem [MAX_ENTRIES];
  logic [TICKET_W-1:0] rd_ticket;
  logic [PID_W-1:0]    rd_id;

  logic             accept;
  logic             div_start;
  logic             div_busy;
  logic             div_done;
  logic [TOT_W-1:0] div_rem;

  logic [BURST_PROD_W-1:0] burst_prod;
  logic [TICKET_W-1:0]     add_tickets;
  logic [TOT_W-1:0]        sum_next;
  logic                    scan_last;

  assign in_stall  = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = in_valid && !in_stall;
  assign div_start = accept && (command == CMD_DRAW) && (entry_count != '0);

  lts_divider #(
    .DIVIDEND_W (RAND_W),
    .DIVISOR_W  (TOT_W)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (random_value),
    .divisor   (ticket_total),
    .busy      (div_busy),
    .done      (div_done),
    .remainder (div_rem)
  );

  always_comb begin
    burst_prod  = BURST_PROD_W'(cur_burst) * BURST_PROD_W'(BURST_RECIP);
    add_tickets = burst_prod[BURST_SHIFT +: TICKET_W] + TICKET_W'(BASE_TICKETS)
                + (cur_bonus ? TICKET_W'(BONUS_TICKETS) : TICKET_W'(0));
    sum_next    = scan_sum + TOT_W'(rd_ticket);
    scan_last   = (CW'(scan_idx) + CW'(1) >= entry_count);
  end

  // ticket and id storage, registered read
  always_ff @(posedge clk) begin
    if (state == S_ADD_WR) begin
      ticket_mem[entry_count[IW-1:0]] <= add_tickets;
      id_mem[entry_count[IW-1:0]]     <= cur_pid;
    end
    rd_ticket <= ticket_mem[scan_idx];
    rd_id     <= id_mem[scan_idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      locality_enabled <= 1'b1;
      bonus_node       <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_LOCALITY:  locality_enabled <= cfg_data[0];
        CFG_PREF_NODE: bonus_node       <= cfg_data[NODE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      entry_count  <= '0;
      ticket_total <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (out_valid && !out_stall && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            cur_bonus  <= locality_enabled && (home_node == bonus_node);
            cur_pid    <= process_id;
            cur_burst  <= run_length;
            res_status <= ST_OK;
            res_widx   <= '0;
            res_wid    <= '0;
            res_tval   <= '0;
            state      <= S_DONE;
            case (command)
              CMD_ADD: begin
                if (entry_count >= CW'(MAX_ENTRIES)) begin
                  res_status <= ST_FULL;
                end else begin
                  state <= S_ADD_WR;
                end
              end
              CMD_DRAW: begin
                if (entry_count == '0) begin
                  res_status <= ST_EMPTY;
                end else begin
                  state <= S_DIV;
                end
              end
              CMD_CLEAR: begin
                entry_count  <= '0;
                ticket_total <= '0;
              end
              default: ;
            endcase
          end
        end
        S_DIV: begin
          if (div_done) begin
            win      <= div_rem + TOT_W'(1);
            scan_sum <= '0;
            scan_idx <= '0;
            state    <= S_SCAN_RD;
          end
        end
        S_ADD_WR: begin
          entry_count  <= entry_count + CW'(1);
          ticket_total <= ticket_total + TOT_W'(add_tickets);
          res_tval     <= add_tickets;
          state        <= S_DONE;
        end
        S_SCAN_RD: begin
          state <= S_SCAN_ACC;
        end
        S_SCAN_ACC: begin
          scan_sum <= sum_next;
          if (sum_next >= win || scan_last) begin
            res_widx <= WIDX_W'(scan_idx);
            res_wid  <= rd_id;
            res_tval <= TICKET_W'(win);
            state    <= S_DONE;
          end else begin
            scan_idx <= scan_idx + IW'(1);
            state    <= S_SCAN_RD;
          end
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            out_valid    <= 1'b1;
            status       <= res_status;
            winner_index <= res_widx;
            winner_id    <= res_wid;
            ticket_value <= res_tval;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `ASSERT_SYNC(a_count_range, clk, rst, entry_count <= CW'(MAX_ENTRIES), "entry count overflow")
  `ASSERT_SYNC(a_total_empty, clk, rst, (entry_count == '0) == (ticket_total == '0), "total/count mismatch")
  `ASSERT_NEXT(a_busy_after_req, clk, rst, accept, in_stall, "request taken but not busy")
  `ASSERT_SYNC(a_scan_range, clk, rst, (state != S_SCAN_ACC) || (CW'(scan_idx) < entry_count), "scan past last entry")
  `ASSERT_SYNC(a_div_wait, clk, rst, (state != S_DIV) || div_busy || div_done, "divider idle while waited on")

endmodule

@@ tb/tb_lottery_ticket_scheduler.sv @@
// ----------------------------------------------------------------------------
// tb_lottery_ticket_scheduler
// Self-checking bench for the lottery scheduler table. A queue of add, draw,
// clear and unused-command requests feeds a clocked driver; a clocked monitor
// compares every result with a cycle-free prediction of the table. Config
// writes happen between phases while the block is idle; both sides stall at
// random, with one long output hold-off that backs up the input.
// ----------------------------------------------------------------------------
module tb_lottery_ticket_scheduler;
  timeunit 1ns;
  timeprecision 1ps;

  import lts_pkg::*;

  localparam int SLOTS        = 16;
  localparam int RESET_CYCLES = 6;
  localparam int SETTLE       = 12;
  localparam int HOLD_CYCLES  = 400;
  localparam int PHASE_ITEMS  = 260;
  localparam int CYCLE_LIMIT  = 800000;

  localparam logic [CMD_W-1:0] CMD_NOP = 2'd3;

  typedef struct packed {
    logic [CMD_W-1:0]   command;
    logic [BURST_W-1:0] burst;
    logic [NODE_W-1:0]  node;
    logic [PID_W-1:0]   pid;
    logic [RAND_W-1:0]  rnd;
  } sched_req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [WIDX_W-1:0]   widx;
    logic [PID_W-1:0]    wid;
    logic [TICKET_W-1:0] tval;
  } sched_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                  in_valid     = 1'b0;
  logic                  in_stall;
  logic [CMD_W-1:0]      command      = '0;
  logic [BURST_W-1:0]    run_length   = '0;
  logic [NODE_W-1:0]     home_node    = '0;
  logic [PID_W-1:0]      process_id   = '0;
  logic [RAND_W-1:0]     random_value = '0;
  logic                  out_valid;
  logic                  out_stall    = 1'b0;
  logic [STATUS_W-1:0]   status;
  logic [WIDX_W-1:0]     winner_index;
  logic [PID_W-1:0]      winner_id;
  logic [TICKET_W-1:0]   ticket_value;
  logic                  cfg_valid    = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index    = '0;
  logic [CFG_DATA_W-1:0] cfg_data     = '0;

  // predicted table state and config
  logic [TICKET_W-1:0] slot_tickets [SLOTS];
  logic [PID_W-1:0]    slot_ids     [SLOTS];
  logic [4:0]          entry_count  = '0;
  logic [16:0]         ticket_total = '0;
  logic                locality_on  = 1'b1;
  logic [NODE_W-1:0]   pref_node    = '0;

  sched_req_t    pending[$];
  sched_result_t results_due[$];

  logic idle_on    = 1'b1;
  int   send_gap   = 0;
  int   stall_left = 0;
  int   hold_trig  = 0;
  int   hold_seen  = 0;
  int   fails      = 0;
  int   cycle_count = 0;

  lottery_ticket_scheduler u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .command      (command),
    .run_length   (run_length),
    .home_node    (home_node),
    .process_id   (process_id),
    .random_value (random_value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .winner_index (winner_index),
    .winner_id    (winner_id),
    .ticket_value (ticket_value),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic sched_result_t predict_result(sched_req_t req);
    sched_result_t res;
    logic [TICKET_W-1:0] t;
    logic [RAND_W-1:0]   win;
    logic [16:0]         sum;
    logic                found;
    res = '0;
    case (req.command)
      CMD_ADD: begin
        if (entry_count >= SLOTS) begin
          res.status = ST_FULL;
        end else begin
          t = TICKET_W'(req.burst / BURST_DIV + BASE_TICKETS);
          if (locality_on && req.node == pref_node) t = TICKET_W'(t + BONUS_TICKETS);
          slot_tickets[entry_count[3:0]] = t;
          slot_ids[entry_count[3:0]]     = req.pid;
          entry_count  = 5'(entry_count + 1);
          ticket_total = ticket_total + t;
          res.tval     = t;
        end
      end
      CMD_DRAW: begin
        if (entry_count == 0 || ticket_total == 0) begin
          res.status = ST_EMPTY;
        end else begin
          win   = req.rnd % {15'd0, ticket_total} + 1;
          sum   = '0;
          found = 1'b0;
          for (int i = 0; i < SLOTS; i++) begin
            if (!found && i < entry_count) begin
              sum = sum + slot_tickets[i];
              if ({15'd0, sum} >= win) begin
                found    = 1'b1;
                res.widx = i[WIDX_W-1:0];
                res.wid  = slot_ids[i];
              end
            end
          end
          res.tval = win[TICKET_W-1:0];
        end
      end
      CMD_CLEAR: begin
        entry_count  = '0;
        ticket_total = '0;
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic sched_req_t make_req(logic [CMD_W-1:0] cmd, logic [BURST_W-1:0] burst,
                                          logic [NODE_W-1:0] node, logic [PID_W-1:0] pid,
                                          logic [RAND_W-1:0] rnd);
    sched_req_t req;
    req.command = cmd;
    req.burst   = burst;
    req.node    = node;
    req.pid     = pid;
    req.rnd     = rnd;
    return req;
  endfunction

  function automatic sched_req_t random_req();
    sched_req_t req;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 45)      req.command = CMD_ADD;
    else if (pick < 85) req.command = CMD_DRAW;
    else if (pick < 95) req.command = CMD_CLEAR;
    else                req.command = CMD_NOP;
    case ($urandom_range(0, 3))
      0:       req.burst = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      1:       req.burst = BURST_W'($urandom_range(0, 99));
      default: req.burst = BURST_W'($urandom);
    endcase
    req.node = $urandom_range(0, 1) ? pref_node : NODE_W'($urandom_range(0, 15));
    req.pid  = PID_W'($urandom);
    req.rnd  = ($urandom_range(0, 3) == 0) ? RAND_W'($urandom_range(0, 20000)) : $urandom;
    return req;
  endfunction

  // request driver
  always @(posedge clk) begin : drive_requests
    logic take;
    take = in_valid && !in_stall;
    if (rst) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (take) results_due.push_back(predict_result(pending.pop_front()));
      if (in_valid && !take) begin
        // stalled: payload held
      end else if (send_gap > 0) begin
        send_gap = send_gap - 1;
        in_valid <= 1'b0;
      end else if (pending.size() != 0) begin
        in_valid     <= 1'b1;
        command      <= pending[0].command;
        run_length   <= pending[0].burst;
        home_node    <= pending[0].node;
        process_id   <= pending[0].pid;
        random_value <= pending[0].rnd;
        if (idle_on && $urandom_range(0, 4) == 0) send_gap = $urandom_range(1, 5);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // output back-pressure
  always @(posedge clk) begin
    if (rst) begin
      stall_left = 0;
    end else if (hold_seen != hold_trig) begin
      hold_seen  = hold_trig;
      stall_left = HOLD_CYCLES;
    end else if (stall_left > 0) begin
      stall_left = stall_left - 1;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 5);
    end
    out_stall <= !rst && stall_left != 0;
  end

  // result checker
  always @(posedge clk) begin : check_results
    sched_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (results_due.size() == 0) begin
        $error("unexpected result: status %0d ticket_value %0d", status, ticket_value);
        fails++;
      end else begin
        want = results_due.pop_front();
        if (status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, status);
          fails++;
        end
        if (winner_index !== want.widx) begin
          $error("winner_index: expected %0d, actual %0d", want.widx, winner_index);
          fails++;
        end
        if (winner_id !== want.wid) begin
          $error("winner_id: expected %0d, actual %0d", want.wid, winner_id);
          fails++;
        end
        if (ticket_value !== want.tval) begin
          $error("ticket_value: expected %0d, actual %0d", want.tval, ticket_value);
          fails++;
        end
      end
    end
  end

  task automatic wait_idle();
    while (pending.size() != 0 || results_due.size() != 0 || in_valid) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == CFG_LOCALITY) locality_on = data[0];
    else pref_node = data;
  endtask

  task automatic queue_random(input int n);
    for (int i = 0; i < n; i++) pending.push_back(random_req());
  endtask

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: reset config, locality on, preferred node 0
    pending.push_back(make_req(CMD_DRAW, 16'h1234, 4'd3, 22'h1, 32'hDEAD_BEEF));
    pending.push_back(make_req(CMD_NOP, 16'hFFFF, 4'hF, 22'h3FFFFF, 32'hFFFF_FFFF));
    pending.push_back(make_req(CMD_ADD, 16'h0000, 4'd0, 22'h000000, 32'h0));
    pending.push_back(make_req(CMD_ADD, 16'hFFFF, 4'hF, 22'h3FFFFF, 32'hFFFF_FFFF));
    pending.push_back(make_req(CMD_ADD, 16'hFFFF, 4'd0, 22'h001234, 32'h0));
    pending.push_back(make_req(CMD_DRAW, 16'h0, 4'd0, 22'h0, 32'h0000_0000));
    pending.push_back(make_req(CMD_DRAW, 16'h0, 4'd0, 22'h0, 32'hFFFF_FFFF));
    // winning ticket above 13 bits
    pending.push_back(make_req(CMD_DRAW, 16'h0, 4'd0, 22'h0, 32'd13145));
    for (int i = 0; i < 13; i++)
      pending.push_back(make_req(CMD_ADD, 16'd0, 4'd1, PID_W'(22'h2AAAAA + i), 32'h0));
    // table full
    pending.push_back(make_req(CMD_ADD, 16'd500, 4'd0, 22'h155555, 32'h0));
    // last slot wins
    pending.push_back(make_req(CMD_DRAW, 16'h0, 4'd0, 22'h0, 32'd13275));
    pending.push_back(make_req(CMD_CLEAR, 16'hFFFF, 4'hF, 22'h3FFFFF, 32'hFFFF_FFFF));
    pending.push_back(make_req(CMD_DRAW, 16'h0, 4'd0, 22'h0, 32'h5));
    wait_idle();

    write_reg(CFG_PREF_NODE, 4'hF);
    write_reg(CFG_LOCALITY, 4'h0);
    queue_random(PHASE_ITEMS);
    wait_idle();

    write_reg(CFG_LOCALITY, 4'h1);
    queue_random(PHASE_ITEMS);
    repeat (40) @(posedge clk);
    hold_trig = hold_trig + 1;
    wait_idle();

    write_reg(CFG_PREF_NODE, CFG_DATA_W'($urandom_range(1, 14)));
    queue_random(PHASE_ITEMS);
    wait_idle();

    idle_on = 1'b0;
    write_reg(CFG_PREF_NODE, 4'h0);
    queue_random(PHASE_ITEMS);
    wait_idle();
    repeat (50) @(posedge clk);

    if (results_due.size() != 0) $error("%0d results never arrived", results_due.size());
    if (fails == 0 && results_due.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
